// ===== rtl/svr_pkg.sv =====
`default_nettype none
package svr_pkg;

  localparam int SAMPLE_RATE_HZ   = 48000;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;

  localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_DEPTH     = SINE_TABLE_DEPTH / 4;
  localparam int QTR_IDX_BITS  = SINE_IDX_BITS - 1;
  localparam int NOTE_COUNT    = 128;

  localparam int KIND_BITS     = 2;
  localparam int NOTE_BITS     = 7;
  localparam int LEVEL_BITS    = 16;
  localparam int GAIN_BITS     = 17;
  localparam int DECAY_BITS    = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int SINE_MAG_BITS = 15;

  localparam int MUL_A_BITS = 31;
  localparam int MUL_B_BITS = 17;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 1'd1;

  localparam logic [DECAY_BITS-1:0] DECAY_RESET  = 16'd64881;
  localparam logic [GAIN_BITS-1:0]  THRESH_RESET = 17'd327;
  localparam logic [GAIN_BITS-1:0]  UNITY_GAIN   = 17'h10000;

  localparam logic [KIND_BITS-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_START = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_STOP  = 2'd2;

  localparam logic [63:0] SEMI_Q31 = 64'd2275179671;
  localparam logic [63:0] PI_Q29   = 64'd1686629713;

  typedef logic [SINE_MAG_BITS-1:0] qtr_tab_t [QTR_DEPTH+1];
  typedef logic [PHASE_BITS-1:0] step_tab_t [NOTE_COUNT];

  // Taylor series of sin(x) to x^15, x and result in Q3.29.
  function automatic logic [63:0] qsin_q29(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 29;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 29) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  function automatic qtr_tab_t build_qtr();
    qtr_tab_t    tab;
    logic [63:0] x;
    logic [63:0] v;
    for (int j = 0; j <= QTR_DEPTH; j++) begin
      x = (PI_Q29 * 64'(4 * j)) / 64'(2 * SINE_TABLE_DEPTH);
      v = (qsin_q29(x) * 64'd32767 + (64'd1 << 28)) >> 29;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[j] = v[SINE_MAG_BITS-1:0];
    end
    return tab;
  endfunction

  function automatic step_tab_t build_steps();
    step_tab_t   tab;
    logic [63:0] ratio [12];
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] step;
    int          d;
    int          oct;
    int          semi;
    int          sh;
    ratio[0] = 64'd1 << 31;
    for (int i = 1; i < 12; i++) begin
      ratio[i] = (ratio[i-1] * SEMI_Q31 + (64'd1 << 30)) >> 31;
    end
    for (int n = 0; n < NOTE_COUNT; n++) begin
      d    = n - 69 + 120;
      oct  = d / 12 - 10;
      semi = d % 12;
      num  = 64'd440 * ratio[semi];
      q    = (num << 22) / 64'(SAMPLE_RATE_HZ);
      sh   = 53 - PHASE_BITS - oct;
      if (sh < 1) begin
        sh = 1;
      end
      if (sh > 62) begin
        sh = 62;
      end
      step   = (q + (64'd1 << (sh - 1))) >> sh;
      tab[n] = step[PHASE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam qtr_tab_t  SINE_QTR_TAB  = build_qtr();
  localparam step_tab_t NOTE_STEP_TAB = build_steps();

endpackage
`default_nettype wire

// ===== rtl/svr_cmd_if.sv =====
`default_nettype none
interface svr_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [svr_pkg::KIND_BITS-1:0]  kind;
  logic [svr_pkg::NOTE_BITS-1:0]  note;
  logic [svr_pkg::LEVEL_BITS-1:0] velocity;
  logic                          allow_tail_off;

  modport source(output valid, kind, note, velocity, allow_tail_off, input ready);
  modport sink(input valid, kind, note, velocity, allow_tail_off, output ready);
endinterface
`default_nettype wire

// ===== rtl/svr_smp_if.sv =====
`default_nettype none
interface svr_smp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svr_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                  voice_active;

  modport source(output valid, sample_out, voice_active, input ready);
  modport sink(input valid, sample_out, voice_active, output ready);
endinterface
`default_nettype wire

// ===== rtl/svr_mul.sv =====
`default_nettype none
module svr_mul (
  input  wire logic                           clk,
  input  wire logic [svr_pkg::MUL_A_BITS-1:0] a,
  input  wire logic [svr_pkg::MUL_B_BITS-1:0] b,
  output logic      [svr_pkg::MUL_P_BITS-1:0] p
);

  always_ff @(posedge clk) begin
    p <= svr_pkg::MUL_P_BITS'(a) * svr_pkg::MUL_P_BITS'(b);
  end

endmodule
`default_nettype wire

// ===== rtl/sine_voice_with_release_core.sv =====
// Note start, note stop and unknown kinds produce no beat and leave the block ready.
// A sounding tick uses one shared 31x17 multiplier for sine times level, times gain
// and the release decay, stepping through S_MUL1, S_MUL2, S_MUL3, S_REL while releasing
// and S_EMIT; a silent tick goes straight to S_EMIT. S_EMIT registers the beat once any
// earlier beat has been taken downstream, and the next item is taken back in S_IDLE.
// Synchronous active-high reset silences the voice and restores the register defaults.
`default_nettype none
module sine_voice_with_release_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  svr_cmd_if.sink                                cmd,
  svr_smp_if.source                              smp,
  input  wire logic                              cfg_we,
  input  wire logic [svr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [svr_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_REL,
    S_EMIT
  } state_t;

  state_t                              state;
  logic [svr_pkg::DECAY_BITS-1:0]      decay;
  logic [svr_pkg::GAIN_BITS-1:0]       thresh;
  logic [svr_pkg::PHASE_BITS-1:0]      phase;
  logic [svr_pkg::PHASE_BITS-1:0]      step;
  logic [svr_pkg::LEVEL_BITS-1:0]      level;
  logic [svr_pkg::GAIN_BITS-1:0]       tail;
  logic                                sounding;
  logic [svr_pkg::SINE_MAG_BITS-1:0]   sin_mag;
  logic                                sin_neg;
  logic [svr_pkg::SAMPLE_BITS-1:0]     mag;
  logic                                out_valid;
  logic signed [svr_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                voice_active;

  logic [svr_pkg::MUL_A_BITS-1:0]      mul_a;
  logic [svr_pkg::MUL_B_BITS-1:0]      mul_b;
  logic [svr_pkg::MUL_P_BITS-1:0]      mul_p;

  logic [svr_pkg::SINE_IDX_BITS-1:0]   sidx;
  logic [1:0]                          quad;
  logic [svr_pkg::QTR_IDX_BITS-1:0]    qidx;
  logic [svr_pkg::MUL_P_BITS-1:0]      mag_sum;
  logic [svr_pkg::MUL_P_BITS-1:0]      tail_sum;
  logic [svr_pkg::GAIN_BITS-1:0]       tail_next;
  logic [svr_pkg::GAIN_BITS-1:0]       gain;

  svr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    sidx = phase[svr_pkg::PHASE_BITS-1 -: svr_pkg::SINE_IDX_BITS];
    quad = sidx[svr_pkg::SINE_IDX_BITS-1 -: 2];
    if (quad[0]) begin
      qidx = svr_pkg::QTR_IDX_BITS'(svr_pkg::QTR_DEPTH)
           - {1'b0, sidx[svr_pkg::SINE_IDX_BITS-3:0]};
    end else begin
      qidx = {1'b0, sidx[svr_pkg::SINE_IDX_BITS-3:0]};
    end
    gain      = (tail == '0) ? svr_pkg::UNITY_GAIN : tail;
    mag_sum   = mul_p + (svr_pkg::MUL_P_BITS'(1) << 31);
    tail_sum  = mul_p + svr_pkg::MUL_P_BITS'(32768);
    tail_next = tail_sum[16 +: svr_pkg::GAIN_BITS];
  end

  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = svr_pkg::MUL_A_BITS'(sin_mag);
        mul_b = svr_pkg::MUL_B_BITS'(level);
      end
      S_MUL2: begin
        mul_a = mul_p[svr_pkg::MUL_A_BITS-1:0];
        mul_b = gain;
      end
      default: begin
        mul_a = svr_pkg::MUL_A_BITS'(tail);
        mul_b = svr_pkg::MUL_B_BITS'(decay);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      decay     <= svr_pkg::DECAY_RESET;
      thresh    <= svr_pkg::THRESH_RESET;
      phase     <= '0;
      step      <= '0;
      level     <= '0;
      tail      <= '0;
      sounding  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          svr_pkg::REG_DECAY:  decay  <= cfg_wdata[svr_pkg::DECAY_BITS-1:0];
          svr_pkg::REG_THRESH: thresh <= cfg_wdata;
          default: ;
        endcase
      end
      if (smp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.kind)
              svr_pkg::KIND_START: begin
                phase    <= '0;
                level    <= cmd.velocity;
                tail     <= '0;
                step     <= svr_pkg::NOTE_STEP_TAB[cmd.note];
                sounding <= 1'b1;
              end
              svr_pkg::KIND_STOP: begin
                if (cmd.allow_tail_off) begin
                  if (tail == '0) begin
                    tail <= svr_pkg::UNITY_GAIN;
                  end
                end else begin
                  sounding <= 1'b0;
                  step     <= '0;
                end
              end
              svr_pkg::KIND_TICK: begin
                sin_mag <= svr_pkg::SINE_QTR_TAB[qidx];
                sin_neg <= quad[1];
                if (sounding) begin
                  state <= S_MUL1;
                end else begin
                  mag   <= '0;
                  state <= S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: begin
          mag   <= mag_sum[32 +: svr_pkg::SAMPLE_BITS];
          phase <= phase + step;
          state <= (tail == '0) ? S_EMIT : S_REL;
        end
        S_REL: begin
          tail <= tail_next;
          if (tail_next <= thresh) begin
            sounding <= 1'b0;
            step     <= '0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || smp.ready) begin
            out_valid    <= 1'b1;
            sample_out   <= sin_neg ? -$signed(mag) : $signed(mag);
            voice_active <= sounding;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready        = (state == S_IDLE);
  assign smp.valid        = out_valid;
  assign smp.sample_out   = sample_out;
  assign smp.voice_active = voice_active;

endmodule
`default_nettype wire

// ===== rtl/svr_checker.sv =====
`default_nettype none
module svr_checker (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   in_valid,
  input wire logic                                   in_ready,
  input wire logic [svr_pkg::KIND_BITS-1:0]          in_kind,
  input wire logic                                   out_valid,
  input wire logic                                   out_ready,
  input wire logic signed [svr_pkg::SAMPLE_BITS-1:0] out_sample
);

  // Reset leaves no beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat pending after reset");

  // A stalled beat keeps its sample.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled output beat changed");

  // A tick occupies the block, which drops ready right after accepting it.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == svr_pkg::KIND_TICK |=> !in_ready)
    else $error("ready right after a tick");

  // Any other item is absorbed and leaves the block ready in the next cycle.
  a_cmd_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind != svr_pkg::KIND_TICK |=> in_ready)
    else $error("not ready after a note command");

  // A tick never produces its beat in the following cycle.
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == svr_pkg::KIND_TICK && !out_valid |=> !out_valid)
    else $error("beat appeared too early");

endmodule

bind sine_voice_with_release_core svr_checker u_svr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd.valid),
  .in_ready   (cmd.ready),
  .in_kind    (cmd.kind),
  .out_valid  (smp.valid),
  .out_ready  (smp.ready),
  .out_sample (smp.sample_out)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;

  typedef longint unsigned u64_t;

  localparam logic [svr_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam u64_t PI_Q3_29 = 64'd1686629713;
  localparam u64_t SEMITONE_Q1_31 = 64'd2275179671;
  localparam int SEGMENT_ITEMS = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER = 100;

  typedef struct packed {
    logic [svr_pkg::KIND_BITS-1:0]  kind;
    logic [svr_pkg::NOTE_BITS-1:0]  note;
    logic [svr_pkg::LEVEL_BITS-1:0] velocity;
    logic                           tail_ok;
  } voice_cmd_t;

  typedef struct packed {
    logic signed [svr_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   active;
  } voice_smp_t;

  typedef struct packed {
    logic [svr_pkg::KIND_BITS-1:0]          kind;
    logic [svr_pkg::NOTE_BITS-1:0]          note;
    logic [svr_pkg::LEVEL_BITS-1:0]         velocity;
    logic                                   tail_ok;
    logic                                   pinned;
    logic signed [svr_pkg::SAMPLE_BITS-1:0] pin_sample;
    logic                                   pin_active;
  } script_row_t;

  localparam script_row_t SCRIPT [24] = '{
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b0},
    '{KIND_UNUSED,         7'd127, 16'hFFFF, 1'b1, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b0},
    '{svr_pkg::KIND_STOP,  7'd0,   16'd0,    1'b1, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b0},
    '{svr_pkg::KIND_START, 7'd127, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b1},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_STOP,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b0},
    '{svr_pkg::KIND_START, 7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b1},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b1, 16'sd0, 1'b1},
    '{svr_pkg::KIND_START, 7'd69,  16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_STOP,  7'd0,   16'd0,    1'b1, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_STOP,  7'd0,   16'd0,    1'b1, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_START, 7'd105, 16'h8000, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{svr_pkg::KIND_TICK,  7'd0,   16'd0,    1'b0, 1'b0, 16'sd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [svr_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [svr_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  always #1 clk = ~clk;

  svr_cmd_if cmd_ch();
  svr_smp_if smp_ch();

  sine_voice_with_release_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .smp(smp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic signed [svr_pkg::SAMPLE_BITS-1:0] sine_rom [svr_pkg::SINE_TABLE_DEPTH];
  logic [svr_pkg::PHASE_BITS-1:0] pitch_rom [svr_pkg::NOTE_COUNT];
  logic [svr_pkg::PHASE_BITS-1:0] osc_phase;
  logic [svr_pkg::PHASE_BITS-1:0] osc_step;
  logic [svr_pkg::LEVEL_BITS-1:0] osc_level;
  logic [svr_pkg::GAIN_BITS-1:0] release_gain;
  logic [svr_pkg::GAIN_BITS-1:0] gain_floor;
  logic [svr_pkg::DECAY_BITS-1:0] gain_decay;
  logic osc_sounding;

  voice_smp_t expected_samples [$];
  int unsigned error_count = 0;
  int unsigned samples_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic u64_t taylor_sin_q29(input u64_t x);
    u64_t x2;
    u64_t term;
    longint acc;
    x2 = (x * x) >> 29;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 29) / u64_t'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return u64_t'(acc);
  endfunction

  function automatic void build_roms();
    u64_t ratio [12];
    u64_t pos;
    u64_t quad;
    u64_t rem;
    u64_t r;
    u64_t x;
    u64_t v;
    u64_t num;
    u64_t q;
    u64_t stp;
    int d;
    int oct;
    int semi;
    int sh;
    for (int i = 0; i < svr_pkg::SINE_TABLE_DEPTH; i++) begin
      pos = u64_t'(4 * i);
      quad = pos / u64_t'(svr_pkg::SINE_TABLE_DEPTH);
      rem = pos % u64_t'(svr_pkg::SINE_TABLE_DEPTH);
      r = quad[0] ? u64_t'(svr_pkg::SINE_TABLE_DEPTH) - rem : rem;
      x = (PI_Q3_29 * r) / u64_t'(2 * svr_pkg::SINE_TABLE_DEPTH);
      v = (taylor_sin_q29(x) * 64'd32767 + (64'd1 << 28)) >> 29;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      sine_rom[i] = (quad >= 64'd2) ? -v[15:0] : v[15:0];
    end
    ratio[0] = 64'd1 << 31;
    for (int i = 1; i < 12; i++) begin
      ratio[i] = (ratio[i-1] * SEMITONE_Q1_31 + (64'd1 << 30)) >> 31;
    end
    for (int n = 0; n < svr_pkg::NOTE_COUNT; n++) begin
      d = n - 69 + 120;
      oct = d / 12 - 10;
      semi = d % 12;
      num = 64'd440 * ratio[semi];
      q = (num << 22) / u64_t'(svr_pkg::SAMPLE_RATE_HZ);
      sh = 53 - svr_pkg::PHASE_BITS - oct;
      if (sh < 1) begin
        sh = 1;
      end
      if (sh > 62) begin
        sh = 62;
      end
      stp = (q + (64'd1 << (sh - 1))) >> sh;
      pitch_rom[n] = stp[svr_pkg::PHASE_BITS-1:0];
    end
  endfunction

  function automatic bit next_voice_sample(input voice_cmd_t c, output voice_smp_t res);
    int sv;
    u64_t pos;
    u64_t gain;
    u64_t mag;
    u64_t g;
    logic [svr_pkg::SINE_IDX_BITS-1:0] idx;
    res = '0;
    case (c.kind)
      svr_pkg::KIND_START: begin
        osc_phase = '0;
        osc_level = c.velocity;
        release_gain = '0;
        osc_step = pitch_rom[c.note];
        osc_sounding = 1'b1;
        return 1'b0;
      end
      svr_pkg::KIND_STOP: begin
        if (c.tail_ok) begin
          if (release_gain == '0) begin
            release_gain = svr_pkg::UNITY_GAIN;
          end
        end else begin
          osc_sounding = 1'b0;
          osc_step = '0;
        end
        return 1'b0;
      end
      svr_pkg::KIND_TICK: begin
      end
      default: begin
        return 1'b0;
      end
    endcase
    if (osc_sounding) begin
      pos = (u64_t'(osc_phase) * u64_t'(svr_pkg::SINE_TABLE_DEPTH)) >> svr_pkg::PHASE_BITS;
      idx = pos[svr_pkg::SINE_IDX_BITS-1:0];
      sv = int'(sine_rom[idx]);
      gain = (release_gain != '0) ? u64_t'(release_gain) : u64_t'(svr_pkg::UNITY_GAIN);
      mag = u64_t'(sv < 0 ? -sv : sv) * u64_t'(osc_level) * gain;
      mag = (mag + (64'd1 << 31)) >> 32;
      res.sample = (sv < 0) ? -mag[15:0] : mag[15:0];
      osc_phase = osc_phase + osc_step;
      if (release_gain != '0) begin
        g = (u64_t'(release_gain) * u64_t'(gain_decay) + 64'd32768) >> 16;
        release_gain = g[svr_pkg::GAIN_BITS-1:0];
        if (release_gain <= gain_floor) begin
          osc_sounding = 1'b0;
          osc_step = '0;
        end
      end
    end
    res.active = osc_sounding;
    return 1'b1;
  endfunction

  function automatic voice_cmd_t random_cmd();
    voice_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c.note = svr_pkg::NOTE_BITS'($urandom_range(svr_pkg::NOTE_COUNT - 1));
    c.velocity = svr_pkg::LEVEL_BITS'($urandom_range(65535));
    c.tail_ok = ($urandom_range(3) != 0);
    if (pick < 10) begin
      c.kind = svr_pkg::KIND_START;
    end else if (pick < 18) begin
      c.kind = svr_pkg::KIND_STOP;
    end else if (pick < 21) begin
      c.kind = KIND_UNUSED;
    end else begin
      c.kind = svr_pkg::KIND_TICK;
    end
    return c;
  endfunction

  task automatic offer_cmd(input voice_cmd_t c, input bit pinned, input voice_smp_t pin);
    voice_smp_t predicted;
    bit emits;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= c.kind;
    cmd_ch.note <= c.note;
    cmd_ch.velocity <= c.velocity;
    cmd_ch.allow_tail_off <= c.tail_ok;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    emits = next_voice_sample(c, predicted);
    if (emits) begin
      expected_samples.push_back(pinned ? pin : predicted);
    end
  endtask

  task automatic settle_block();
    cmd_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [svr_pkg::DECAY_BITS-1:0] decay,
                               input logic [svr_pkg::GAIN_BITS-1:0] floor_gain);
    cfg_we <= 1'b1;
    cfg_index <= svr_pkg::REG_DECAY;
    cfg_wdata <= svr_pkg::CFG_DATA_BITS'(decay);
    @(posedge clk);
    cfg_index <= svr_pkg::REG_THRESH;
    cfg_wdata <= svr_pkg::CFG_DATA_BITS'(floor_gain);
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_decay = decay;
    gain_floor = floor_gain;
  endtask

  always @(posedge clk) begin
    voice_smp_t want;
    if (smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        error_count++;
        $error("sample beat with none expected: sample_out %0d voice_active %0b",
               smp_ch.sample_out, smp_ch.voice_active);
      end else begin
        want = expected_samples.pop_front();
        if (smp_ch.sample_out !== want.sample) begin
          error_count++;
          $error("sample_out expected %0d actual %0d", want.sample, smp_ch.sample_out);
        end
        if (smp_ch.voice_active !== want.active) begin
          error_count++;
          $error("voice_active expected %0b actual %0b", want.active, smp_ch.voice_active);
        end
      end
    end
  end

  // The long hold lets the block fill up while ticks keep arriving.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    smp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        smp_ch.ready <= 1'b0;
      end else if (!hold_done && samples_seen >= LONG_HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        smp_ch.ready <= 1'b0;
      end else begin
        smp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #1000000;
    $display("sine_voice_with_release_core verification failed");
    $finish;
  end

  initial begin
    voice_cmd_t c;
    voice_smp_t pin;
    int made;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.kind <= svr_pkg::KIND_TICK;
    cmd_ch.note <= '0;
    cmd_ch.velocity <= '0;
    cmd_ch.allow_tail_off <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= svr_pkg::REG_DECAY;
    cfg_wdata <= '0;
    build_roms();
    gain_decay = 16'd64881;
    gain_floor = 17'd327;
    osc_phase = '0;
    osc_step = '0;
    osc_level = '0;
    release_gain = '0;
    osc_sounding = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 49;
    foreach (SCRIPT[i]) begin
      c = '{SCRIPT[i].kind, SCRIPT[i].note, SCRIPT[i].velocity, SCRIPT[i].tail_ok};
      pin = '{SCRIPT[i].pin_sample, SCRIPT[i].pin_active};
      offer_cmd(c, SCRIPT[i].pinned, pin);
    end

    for (int seg = 0; seg < 4; seg++) begin
      settle_block();
      case (seg)
        0: begin
          load_settings(16'd50000, 17'd4000);
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 15;
          load_settings(16'hFFFF, 17'h10000);
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          load_settings(16'd0, 17'd0);
        end
        default: begin
          load_settings(svr_pkg::DECAY_BITS'($urandom_range(45000, 65535)),
                        svr_pkg::GAIN_BITS'($urandom_range(0, 65536)));
        end
      endcase
      made = 0;
      while (made < SEGMENT_ITEMS) begin
        c = random_cmd();
        offer_cmd(c, 1'b0, '0);
        if (c.kind != KIND_UNUSED) begin
          made++;
        end
      end
    end

    settle_block();
    if (error_count == 0) begin
      $display("sine_voice_with_release_core verification clean");
    end else begin
      $display("sine_voice_with_release_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/svr_pkg.sv
rtl/svr_cmd_if.sv
rtl/svr_smp_if.sv
rtl/svr_mul.sv
rtl/sine_voice_with_release_core.sv
rtl/svr_checker.sv
tb/testbench.sv
